>>> sv/taa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, status struct and state encodings for the triangle area accumulator.
package taa_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int AREA_BITS      = 34;
    localparam int TOTAL_BITS     = 56;
    localparam int SQ_DIGIT       = 16;   // multiplier digit width of the squaring unit

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQSUM,
        ST_ROOT,
        ST_EMIT
    } t_top_state;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_MUL,
        SQ_SUB,
        SQ_DIG,
        SQ_ADD
    } t_sq_state;

endpackage

>>> sv/taa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for triangle beats and area result beats.
interface taa_tri_if #(
    parameter int COORD_BITS = taa_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic                         last_face;

    modport source (
        output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_face,
        input  ready
    );
    modport sink (
        input  valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_face,
        output ready
    );
endinterface

interface taa_area_if;
    logic                             valid;
    logic                             ready;
    logic [taa_pkg::AREA_BITS-1:0]    face_area;
    logic [taa_pkg::TOTAL_BITS-1:0]   running_total;
    logic                             total_saturated;

    modport source (
        output valid, face_area, running_total, total_saturated,
        input  ready
    );
    modport sink (
        input  valid, face_area, running_total, total_saturated,
        output ready
    );
endinterface

>>> sv/triangle_area_accumulator.sv
`timescale 1ns / 1ps
// Triangle area accumulator top level: control, saturating total and result register.
//
// Usage notes:
//   i_tri  : one beat per triangle, three signed Q8.8 vertices plus last_face.
//   o_area : one beat per triangle: face_area (units of 2^-16), the running
//            total including this face, and the sticky total_saturated flag.
//   One triangle is in work at a time. The time from accept to o_area.valid
//   is set by the squaring unit, one 16-bit multiplier digit per cycle, and
//   by the square root, one radicand bit pair per cycle, plus the handoffs
//   between the units.
//   The result sits in an output register; i_tri.ready returns as soon as it
//   is loaded, so the next triangle runs while the result waits. If the
//   receiver stalls longer, the finished triangle waits in the engine and
//   i_tri stays not ready.
//   A last_face beat reports the total including itself, then total and flag
//   clear to zero. Reset clears the total, the flag and all control; no
//   result is pending after reset.
module triangle_area_accumulator #(
    parameter int COORD_BITS = taa_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    taa_tri_if.sink     i_tri,
    taa_area_if.source  o_area
);
    import taa_pkg::*;

    localparam int SW = 4 * COORD_BITS + 4;        // squared length
    localparam int QW = SW / 2;                    // root
    localparam int AW = QW - 1;                    // root / 2
    localparam int XW = (AW > AREA_BITS) ? AW : AREA_BITS;

    t_top_state             r_state, n_state;
    logic                   r_last, n_last;
    logic                   r_out_valid, n_out_valid;
    logic [TOTAL_BITS-1:0]  r_sum, n_sum;
    logic                   r_ovf, n_ovf;
    logic [AREA_BITS-1:0]   r_area_o, n_area_o;
    logic [TOTAL_BITS-1:0]  r_total_o, n_total_o;
    logic                   r_sat_o, n_sat_o;

    logic signed [COORD_BITS-1:0] tri_a [3];
    logic signed [COORD_BITS-1:0] tri_b [3];
    logic signed [COORD_BITS-1:0] tri_c [3];

    t_unit_sts              sq_sts, rt_sts;
    logic [SW-1:0]          sq_sum;
    logic [QW-1:0]          root;
    logic                   accept, sq_start, rt_start, emit, out_free;

    logic [XW-1:0]          area_x;
    logic                   area_big;
    logic [AREA_BITS-1:0]   area;
    logic [TOTAL_BITS:0]    sum_w;
    logic                   carry;
    logic [TOTAL_BITS-1:0]  new_total;

    assign tri_a[0] = i_tri.ax;
    assign tri_a[1] = i_tri.ay;
    assign tri_a[2] = i_tri.az;
    assign tri_b[0] = i_tri.bx;
    assign tri_b[1] = i_tri.by;
    assign tri_b[2] = i_tri.bz;
    assign tri_c[0] = i_tri.cx;
    assign tri_c[1] = i_tri.cy;
    assign tri_c[2] = i_tri.cz;

    taa_sqsum #(
        .COORD_BITS (COORD_BITS)
    ) u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_va    (tri_a),
        .i_vb    (tri_b),
        .i_vc    (tri_c),
        .o_sts   (sq_sts),
        .o_sum   (sq_sum)
    );

    taa_isqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rt_start),
        .i_rad   (sq_sum),
        .o_sts   (rt_sts),
        .o_root  (root)
    );

    // area = floor(root / 2), clamped to the field width for wide coordinates
    assign area_x   = XW'(root[QW-1:1]);
    assign area_big = |(area_x >> AREA_BITS);
    assign area     = area_big ? '1 : area_x[AREA_BITS-1:0];

    // carry out of the 57-bit add means the total would pass its maximum
    assign sum_w     = {1'b0, r_sum} + (TOTAL_BITS + 1)'(area);
    assign carry     = sum_w[TOTAL_BITS];
    assign new_total = carry ? '1 : sum_w[TOTAL_BITS-1:0];

    assign out_free    = !r_out_valid || o_area.ready;
    assign i_tri.ready = (r_state == ST_IDLE);
    assign accept      = i_tri.valid && (r_state == ST_IDLE);
    assign sq_start    = accept;
    assign rt_start    = (r_state == ST_SQSUM) && sq_sts.done;
    assign emit        = (r_state == ST_EMIT) && out_free;

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_sum       = r_sum;
        n_ovf       = r_ovf;
        n_area_o    = r_area_o;
        n_total_o   = r_total_o;
        n_sat_o     = r_sat_o;
        n_out_valid = o_area.ready ? 1'b0 : r_out_valid;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_last  = i_tri.last_face;
                    n_state = ST_SQSUM;
                end
            end
            ST_SQSUM: begin
                if (rt_start) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (rt_sts.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    n_area_o    = area;
                    n_total_o   = new_total;
                    n_sat_o     = r_ovf | carry;
                    n_out_valid = 1'b1;
                    // mesh end: clear after reporting
                    n_sum       = r_last ? '0 : new_total;
                    n_ovf       = r_last ? 1'b0 : (r_ovf | carry);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_ovf       <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_area_o  <= n_area_o;
        r_total_o <= n_total_o;
        r_sat_o   <= n_sat_o;
    end

    assign o_area.valid           = r_out_valid;
    assign o_area.face_area       = r_area_o;
    assign o_area.running_total   = r_total_o;
    assign o_area.total_saturated = r_sat_o;

    // ready only while both engines are quiet
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tri.ready |-> (!sq_sts.busy && !rt_sts.busy))
        else $error("input ready while an engine is busy");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tri.valid && i_tri.ready) |=> sq_sts.busy)
        else $error("accepted beat did not start the squaring unit");

    a_root_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rt_sts.done |-> (r_state == ST_ROOT && !sq_sts.done))
        else $error("root finished outside its phase");

    a_sat_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_area.valid && o_area.total_saturated) |-> (&o_area.running_total))
        else $error("saturation flag set with total below maximum");

endmodule

>>> sv/taa_sqsum.sv
`timescale 1ns / 1ps
// Edge vectors, cross product and digit-serial sum of squared cross components.
module taa_sqsum #(
    parameter int COORD_BITS = taa_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_BITS-1:0] i_va [3],
    input  logic signed [COORD_BITS-1:0] i_vb [3],
    input  logic signed [COORD_BITS-1:0] i_vc [3],
    output taa_pkg::t_unit_sts           o_sts,
    output logic [4*COORD_BITS+3:0]      o_sum
);
    import taa_pkg::*;

    localparam int DW   = COORD_BITS + 1;        // edge component
    localparam int PW   = 2 * DW;                // one product
    localparam int NW   = PW + 1;                // cross component, signed
    localparam int MW   = 2 * COORD_BITS + 1;    // |cross component|
    localparam int SQW  = 2 * MW;
    localparam int SW   = 4 * COORD_BITS + 4;
    localparam int NDIG = (MW + SQ_DIGIT - 1) / SQ_DIGIT;
    localparam int DSW  = NDIG * SQ_DIGIT;
    localparam int DCW  = (NDIG > 1) ? $clog2(NDIG) : 1;

    t_sq_state             r_state, n_state;
    logic [1:0]            r_comp, n_comp;
    logic [DCW-1:0]        r_dig, n_dig;
    logic                  r_done, n_done;

    logic signed [DW-1:0]  r_u [3];
    logic signed [DW-1:0]  r_v [3];
    logic signed [DW-1:0]  n_u [3];
    logic signed [DW-1:0]  n_v [3];
    logic signed [PW-1:0]  r_pa, n_pa, r_pb, n_pb;
    logic [MW-1:0]         r_mag, n_mag;
    logic [DSW-1:0]        r_dsh, n_dsh;
    logic [SQW-1:0]        r_sq, n_sq;
    logic [SW-1:0]         r_acc, n_acc;

    logic signed [DW-1:0]  mul_a, mul_b, mul_c, mul_d;
    logic signed [NW-1:0]  diff;
    logic [NW-1:0]         mag_full;
    logic [SQ_DIGIT-1:0]   digit;
    logic [MW+SQ_DIGIT-1:0] part_prod;

    // operand pick: n[k] = u[k+1]*v[k+2] - u[k+2]*v[k+1]
    always_comb begin
        case (r_comp)
            2'd0: begin
                mul_a = r_u[1]; mul_b = r_v[2]; mul_c = r_u[2]; mul_d = r_v[1];
            end
            2'd1: begin
                mul_a = r_u[2]; mul_b = r_v[0]; mul_c = r_u[0]; mul_d = r_v[2];
            end
            default: begin
                mul_a = r_u[0]; mul_b = r_v[1]; mul_c = r_u[1]; mul_d = r_v[0];
            end
        endcase
    end

    assign diff      = {r_pa[PW-1], r_pa} - {r_pb[PW-1], r_pb};
    assign mag_full  = diff[NW-1] ? NW'(-diff) : NW'(diff);
    assign digit     = r_dsh[DSW-1 -: SQ_DIGIT];
    assign part_prod = r_mag * digit;

    always_comb begin
        n_state = r_state;
        n_comp  = r_comp;
        n_dig   = r_dig;
        n_done  = 1'b0;
        n_u     = r_u;
        n_v     = r_v;
        n_pa    = r_pa;
        n_pb    = r_pb;
        n_mag   = r_mag;
        n_dsh   = r_dsh;
        n_sq    = r_sq;
        n_acc   = r_acc;
        case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < 3; k++) begin
                        n_u[k] = {i_vb[k][COORD_BITS-1], i_vb[k]}
                               - {i_va[k][COORD_BITS-1], i_va[k]};
                        n_v[k] = {i_vc[k][COORD_BITS-1], i_vc[k]}
                               - {i_va[k][COORD_BITS-1], i_va[k]};
                    end
                    n_comp  = 2'd0;
                    n_acc   = '0;
                    n_state = SQ_MUL;
                end
            end
            SQ_MUL: begin
                n_pa    = mul_a * mul_b;
                n_pb    = mul_c * mul_d;
                n_state = SQ_SUB;
            end
            SQ_SUB: begin
                n_mag   = mag_full[MW-1:0];
                n_dsh   = DSW'(mag_full[MW-1:0]);
                n_sq    = '0;
                n_dig   = '0;
                n_state = SQ_DIG;
            end
            SQ_DIG: begin
                // MSB-first Horner: sq = sq * 2^D + mag * digit
                n_sq  = (r_sq << SQ_DIGIT) + SQW'(part_prod);
                n_dsh = r_dsh << SQ_DIGIT;
                n_dig = r_dig + 1'b1;
                if (r_dig == DCW'(NDIG - 1)) begin
                    n_state = SQ_ADD;
                end
            end
            SQ_ADD: begin
                n_acc = r_acc + SW'(r_sq);
                if (r_comp == 2'd2) begin
                    n_done  = 1'b1;
                    n_state = SQ_IDLE;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = SQ_MUL;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_comp  <= 2'd0;
            r_dig   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_dig   <= n_dig;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_pa  <= n_pa;
        r_pb  <= n_pb;
        r_mag <= n_mag;
        r_dsh <= n_dsh;
        r_sq  <= n_sq;
        r_acc <= n_acc;
    end

    assign o_sts.busy = (r_state != SQ_IDLE);
    assign o_sts.done = r_done;
    assign o_sum      = r_acc;

endmodule

>>> sv/taa_isqrt.sv
`timescale 1ns / 1ps
// Restoring integer square root, one radicand bit pair per cycle.
module taa_isqrt #(
    parameter int COORD_BITS = taa_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [4*COORD_BITS+3:0]  i_rad,
    output taa_pkg::t_unit_sts       o_sts,
    output logic [2*COORD_BITS+1:0]  o_root
);
    import taa_pkg::*;

    localparam int SW = 4 * COORD_BITS + 4;
    localparam int QW = SW / 2;
    localparam int RW = QW + 1;           // remainder never exceeds 2*root
    localparam int CW = $clog2(QW);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [SW-1:0]   r_rad, n_rad;
    logic [RW-1:0]   r_rem, n_rem;
    logic [QW-1:0]   r_root, n_root;

    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic [RW+1:0]   rem_sub;
    logic            ge;

    assign rem_sh  = {r_rem, r_rad[SW-1 -: 2]};
    assign trial   = (RW + 2)'({r_root, 2'b01});
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (r_busy) begin
            n_rad  = r_rad << 2;
            n_rem  = ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
            n_root = {r_root[QW-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(QW - 1);
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_root;

endmodule
